// ===== hdl/nhfr_pkg.sv =====
// Shared types and constants for the NRZI HDLC frame receiver.
// No dependencies; imported by every module of the block.
package nhfr_pkg;

	// Receive phases
	typedef enum logic [2:0] {
		PH_INIT     = 3'd0,
		PH_PREAMBLE = 3'd1,
		PH_START    = 3'd2,
		PH_PRELOAD  = 3'd3,
		PH_DATA     = 3'd4
	} phase_t;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_DELAY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TIMEOUT = 2'd1;
	localparam int unsigned CFG_DATA_W = 16;

	// Reset values of the registers
	localparam logic [15:0] INIT_DELAY_RST    = 16'd256;
	localparam logic [7:0]  START_TIMEOUT_RST = 8'd24;

	// Pattern and CRC constants
	localparam logic [15:0] PREAMBLE_PAT = 16'h5555;
	localparam logic [7:0]  FLAG_PAT     = 8'h7E;
	localparam logic [5:0]  STUFF_PAT    = 6'b111110;
	localparam logic [15:0] CRC_POLY     = 16'h8408;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_RESIDUE  = 16'hF0B8;
	localparam logic [15:0] PRELOAD_BITS = 16'd8;

	// Default depth of the decoded-bit queue
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// One result item
	typedef struct packed {
		logic       byte_valid;
		logic [7:0] data_byte;
		logic       packet_begin;
		logic       packet_end;
		logic       crc_good;
		logic       pll_acquire;
		logic       dc_acquire;
		logic       receiving;
	} res_t;

endpackage

// ===== hdl/nhfr_front.sv =====
// Front end: takes line samples and NRZI-decodes them into a bit stream.
// Depends on nhfr_pkg; feeds nhfr_queue.
module nhfr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic line_valid,
	output logic line_ready,
	input  logic line_level,
	output logic push,
	output logic push_bit,
	input  logic queue_full
);
	import nhfr_pkg::*;

	logic prev_level_q;

	assign line_ready = !queue_full;
	assign push       = line_valid && !queue_full;
	// same level as the previous sample decodes as 1, a change as 0
	assign push_bit   = (line_level == prev_level_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
		end else if (push) begin
			prev_level_q <= line_level;
		end
	end

endmodule

// ===== hdl/nhfr_queue.sv =====
// Short FIFO of decoded bits between front and back ends.
// Depends on nhfr_pkg for nothing but house style; depth is a parameter.
module nhfr_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_bit,
	output logic full,
	input  logic pop,
	output logic pop_valid,
	output logic pop_bit
);
	import nhfr_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

	logic [DEPTH-1:0] mem_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == DEPTH_C);
	assign pop_valid = (count_q != '0);
	assign pop_bit   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_bit;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// a push is only ever offered when there is room
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	// fill count follows the handshakes
	assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on push");
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_C)
		else $error("queue count above depth");

endmodule

// ===== hdl/nhfr_back.sv =====
// Back end: phase sequencer, destuffing, byte assembly, CRC-16 and the result register.
// Depends on nhfr_pkg; consumes decoded bits from nhfr_queue.
module nhfr_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             bit_valid,
	input  logic                             bit_in,
	output logic                             bit_pop,
	input  logic                             cfg_valid,
	input  logic [nhfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nhfr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                             res_valid,
	input  logic                             res_ready,
	output nhfr_pkg::res_t                   res
);
	import nhfr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  timeout_q;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] shift_q, shift_d;
	logic [7:0]  byte_q, byte_d;
	logic [15:0] crc_q, crc_d;
	logic        pll_q, pll_d;
	logic        dc_q, dc_d;
	logic        led_q, led_d;
	logic        res_valid_q;
	res_t        res_q, res_d;

	logic        step;
	logic [15:0] sh;
	logic [15:0] cnt_inc;
	logic [15:0] cnt_dec;
	logic        is_flag;
	logic        is_stuff;
	logic [7:0]  byte_nx;
	logic [15:0] crc_nx;

	// result register takes a new item when empty or being drained; a
	// register write holds the bit in the queue
	assign step      = bit_valid && !cfg_valid && (!res_valid_q || res_ready);
	assign bit_pop   = step;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// shared decode of the incoming bit
	assign sh       = {shift_q[14:0], bit_in};
	assign cnt_inc  = cnt_q + 16'd1;
	assign cnt_dec  = cnt_q - 16'd1;
	assign is_flag  = (sh[7:0] == FLAG_PAT);
	assign is_stuff = (sh[13:8] == STUFF_PAT);
	assign byte_nx  = {sh[8], byte_q[7:1]};
	assign crc_nx   = (crc_q[0] ^ sh[8]) ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_INIT:     if (cnt_dec == '0) phase_d = PH_PREAMBLE;
			PH_PREAMBLE: if (sh == PREAMBLE_PAT) phase_d = PH_START;
			PH_START: begin
				if (is_flag) begin
					phase_d = PH_PRELOAD;
				end else if (cnt_inc >= {8'd0, timeout_q}) begin
					phase_d = PH_PREAMBLE;
				end
			end
			PH_PRELOAD:  if (cnt_inc == PRELOAD_BITS) phase_d = PH_DATA;
			PH_DATA:     if (is_flag) phase_d = PH_PREAMBLE;
			default:     phase_d = phase_q;
		endcase
	end

	// datapath and result for this bit
	always_comb begin
		cnt_d   = cnt_q;
		shift_d = sh;
		byte_d  = byte_q;
		crc_d   = crc_q;
		pll_d   = pll_q;
		dc_d    = dc_q;
		led_d   = led_q;
		res_d   = '0;
		case (phase_q)
			PH_INIT: begin
				cnt_d = cnt_dec;
				if (cnt_dec == '0) begin
					dc_d    = 1'b1;
					pll_d   = 1'b1;
					shift_d = '0;
				end
			end
			PH_PREAMBLE: begin
				if (sh == PREAMBLE_PAT) begin
					cnt_d = '0;
					pll_d = 1'b0;
				end
			end
			PH_START: begin
				if (is_flag) begin
					cnt_d = '0;
					led_d = 1'b1;
				end else begin
					cnt_d = cnt_inc;
					if (cnt_inc >= {8'd0, timeout_q}) begin
						pll_d = 1'b1;
					end
				end
			end
			PH_PRELOAD: begin
				cnt_d = cnt_inc;
				if (cnt_inc == PRELOAD_BITS) begin
					cnt_d              = '0;
					crc_d              = CRC_INIT;
					res_d.packet_begin = 1'b1;
				end
			end
			PH_DATA: begin
				// stuffed zero after five ones is dropped
				if (!is_stuff) begin
					cnt_d  = cnt_inc;
					byte_d = byte_nx;
					crc_d  = crc_nx;
					if (cnt_inc[2:0] == 3'd0) begin
						res_d.byte_valid = 1'b1;
						res_d.data_byte  = byte_nx;
					end
				end
				if (is_flag) begin
					pll_d            = 1'b1;
					led_d            = 1'b0;
					res_d.packet_end = 1'b1;
					res_d.crc_good   = (crc_d == CRC_RESIDUE);
				end
			end
			default: ;
		endcase
		res_d.pll_acquire = pll_d;
		res_d.dc_acquire  = dc_d;
		res_d.receiving   = led_d;
	end

	// state and configuration registers; a new delay only matters while waiting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_INIT;
			timeout_q    <= START_TIMEOUT_RST;
			cnt_q        <= INIT_DELAY_RST;
			shift_q      <= '0;
			byte_q       <= '0;
			crc_q        <= CRC_INIT;
			pll_q        <= 1'b0;
			dc_q         <= 1'b0;
			led_q        <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INIT_DELAY: begin
					if (phase_q == PH_INIT) begin
						cnt_q <= cfg_data;
					end
				end
				CFG_START_TIMEOUT: timeout_q <= cfg_data[7:0];
				default: ;
			endcase
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			shift_q <= shift_d;
			byte_q  <= byte_d;
			crc_q   <= crc_d;
			pll_q   <= pll_d;
			dc_q    <= dc_d;
			led_q   <= led_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	// PLL acquisition and the receive LED are never up together
	assert property (@(posedge clk) disable iff (!arst_n) !(pll_q && led_q))
		else $error("pll and led both active");
	// LED is lit exactly from the start flag to the end flag
	assert property (@(posedge clk) disable iff (!arst_n)
		led_q == ((phase_q == PH_PRELOAD) || (phase_q == PH_DATA)))
		else $error("led out of step with phase");
	// DC acquisition is low only during the initial delay
	assert property (@(posedge clk) disable iff (!arst_n)
		dc_q == (phase_q != PH_INIT))
		else $error("dc line out of step with phase");
	// a good CRC is only ever reported with an end flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.crc_good) |-> res_q.packet_end)
		else $error("crc_good without packet_end");

endmodule

// ===== hdl/nrzi_hdlc_frame_receiver_unit.sv =====
// Top level of the NRZI HDLC frame receiver.
// Depends on nhfr_pkg, nhfr_front, nhfr_queue and nhfr_back.
//
// Takes one sampled line level per transaction on the slave stream and returns
// one status item per sample on the master stream. Throughput is one sample per
// clock unless a master-side stall or a configuration write holds the back end:
// the NRZI decoder pushes into a QUEUE_DEPTH-entry bit queue, and the back end
// drains it at one bit per cycle into a single output register, so a sample's
// bit is registered in the bit queue and its result in the output register
// before it is presented on the master stream. The bit queue and the output
// register absorb short stalls on the master side. Configuration writes are
// meant for idle periods; a write of init_delay during the initial delay
// reloads the delay counter. There is no clearing pass after reset.
module nrzi_hdlc_frame_receiver_unit #(
	parameter int unsigned QUEUE_DEPTH = nhfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// slave stream: tdata[0] line_level, [7:1] zero
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,
	// master stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// tdata: [7:0] data_byte, [8] packet_begin, [9] crc_good, [10] pll_acquire,
	//        [11] dc_acquire, [12] receiving, [15:13] zero
	output logic [15:0]                      m_tdata,
	// tuser: [0] byte_valid
	output logic                             m_tuser,
	// tlast: packet_end
	output logic                             m_tlast,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [nhfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nhfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import nhfr_pkg::*;

	logic push;
	logic push_bit;
	logic queue_full;
	logic pop;
	logic pop_valid;
	logic pop_bit;
	res_t res;

	assign cfg_ready = 1'b1;

	nhfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_valid (s_tvalid),
		.line_ready (s_tready),
		.line_level (s_tdata[0]),
		.push       (push),
		.push_bit   (push_bit),
		.queue_full (queue_full)
	);

	nhfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_bit  (push_bit),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_bit   (pop_bit)
	);

	nhfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.bit_valid (pop_valid),
		.bit_in    (pop_bit),
		.bit_pop   (pop),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// pack the result onto the master stream
	assign m_tdata = {3'b000, res.receiving, res.dc_acquire, res.pll_acquire,
		res.crc_good, res.packet_begin, res.data_byte};
	assign m_tuser = res.byte_valid;
	assign m_tlast = res.packet_end;

endmodule
